// ===== sv/matrix_multiply_accumulate_macros.svh =====
// assertion macros shared by the matrix multiply-accumulate modules
`ifndef MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MMA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MMA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mma_pkg.sv =====
// shared types and constants of the matrix multiply-accumulate engine
`default_nettype none

package mma_pkg;

	// default and fixed widths
	localparam int MAX_DIM_DEF = 16;
	localparam int ACT_W       = 3;
	localparam int RC_W        = 4;
	localparam int VAL_W       = 32;
	localparam int ACC_W       = 64;
	localparam int SIZE_W      = 5;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_USER_W  = 2;

	localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

	// saturation limits of the accumulator
	localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

	// cycles from the last issued beat until its result is written back
	localparam int DRAIN_CYC = 2;

	// operation codes carried in the input tuser
	typedef enum logic [ACT_W-1:0] {
		ACT_WR_A = 3'd0,
		ACT_WR_B = 3'd1,
		ACT_MAC  = 3'd2,
		ACT_CLR  = 3'd3,
		ACT_RD   = 3'd4
	} action_t;

	// one beat of the multiply-accumulate loop
	typedef struct packed {
		logic issue;
		logic first;
		logic last;
	} mma_ctl_t;

	// one entry of the result store
	typedef struct packed {
		logic signed [ACC_W-1:0] val;
		logic                    mark;
	} c_entry_t;

endpackage

`default_nettype wire

// ===== sv/mma_seq.sv =====
// loop sequencer: walks i, j, k over the active size and drains the pipe
`default_nettype none

module mma_seq #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [$clog2(MAX_DIM+1)-1:0]  n_act,
	output logic      [$clog2(MAX_DIM)-1:0]    idx_i,
	output logic      [$clog2(MAX_DIM)-1:0]    idx_j,
	output logic      [$clog2(MAX_DIM)-1:0]    idx_k,
	output mma_pkg::mma_ctl_t                  ctl,
	output logic                               done
);
	import mma_pkg::*;

	localparam int NW  = $clog2(MAX_DIM+1);
	localparam int DW  = $clog2(MAX_DIM);
	localparam int DRW = $clog2(DRAIN_CYC);
	localparam logic [DRW-1:0] DRAIN_LAST = DRW'(DRAIN_CYC-1);

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_DRAIN
	} seq_state_t;

	seq_state_t      state_q;
	logic [DW-1:0]   i_q, j_q, k_q;
	logic [DRW-1:0]  drain_q;
	logic [DW-1:0]   nm1;
	logic            k_end, j_end, i_end;

	// loop bounds
	assign nm1   = DW'(n_act - NW'(1));
	assign k_end = (k_q == nm1);
	assign j_end = (j_q == nm1);
	assign i_end = (i_q == nm1);

	assign idx_i     = i_q;
	assign idx_j     = j_q;
	assign idx_k     = k_q;
	assign ctl.issue = (state_q == SQ_RUN);
	assign ctl.first = (k_q == '0);
	assign ctl.last  = k_end;
	assign done      = (state_q == SQ_DRAIN) && (drain_q == DRAIN_LAST);

	// loop counters, k innermost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			drain_q <= '0;
		end else begin
			unique case (state_q)
				SQ_IDLE: begin
					if (start) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= SQ_RUN;
					end
				end
				SQ_RUN: begin
					if (k_end) begin
						k_q <= '0;
						if (j_end) begin
							j_q <= '0;
							if (i_end) begin
								drain_q <= '0;
								state_q <= SQ_DRAIN;
							end else begin
								i_q <= i_q + DW'(1);
							end
						end else begin
							j_q <= j_q + DW'(1);
						end
					end else begin
						k_q <= k_q + DW'(1);
					end
				end
				SQ_DRAIN: begin
					drain_q <= drain_q + DRW'(1);
					if (drain_q == DRAIN_LAST) begin
						state_q <= SQ_IDLE;
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/mma_mac.sv =====
// shared multiply and saturating accumulate unit, two pipeline stages
`default_nettype none
`include "matrix_multiply_accumulate_macros.svh"

module mma_mac #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire mma_pkg::mma_ctl_t                      ctl_s0,
	input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     cidx_s0,
	input  wire logic signed [mma_pkg::VAL_W-1:0]       a_rd,
	input  wire logic signed [mma_pkg::VAL_W-1:0]       b_rd,
	input  wire mma_pkg::c_entry_t                      c_rd,
	output logic                                        wr_en,
	output logic      [$clog2(MAX_DIM*MAX_DIM)-1:0]     wr_idx,
	output mma_pkg::c_entry_t                           wr_entry
);
	import mma_pkg::*;

	localparam int IW = $clog2(MAX_DIM*MAX_DIM);

	mma_ctl_t                 ctl_s1, ctl_s2;
	logic [IW-1:0]            cidx_s1, cidx_s2;
	logic signed [ACC_W-1:0]  prod_s2;
	c_entry_t                 c_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     mark_q;
	logic signed [ACC_W-1:0]  base;
	logic                     mark_base;
	logic [ACC_W:0]           sum_w;
	logic                     ovf_now;
	logic signed [ACC_W-1:0]  sat_sum;

	// beat tags follow the data through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
		end
	end

	// stage one: product of the two operand words
	always_ff @(posedge clk) begin
		cidx_s1 <= cidx_s0;
		cidx_s2 <= cidx_s1;
		prod_s2 <= a_rd * b_rd;
		c_s2    <= c_rd;
	end

	// stage two: saturating add onto the stored or running sum
	always_comb begin
		base      = ctl_s2.first ? c_s2.val  : acc_q;
		mark_base = ctl_s2.first ? c_s2.mark : mark_q;
		sum_w     = {base[ACC_W-1], base} + {prod_s2[ACC_W-1], prod_s2};
		ovf_now   = sum_w[ACC_W] ^ sum_w[ACC_W-1];
		if (ovf_now) begin
			sat_sum = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sat_sum = sum_w[ACC_W-1:0];
		end
	end

	// running sum and sticky mark
	always_ff @(posedge clk) begin
		if (ctl_s2.issue) begin
			acc_q  <= sat_sum;
			mark_q <= mark_base | ovf_now;
		end
	end

	// write back after the last k
	assign wr_en         = ctl_s2.issue && ctl_s2.last;
	assign wr_idx        = cidx_s2;
	assign wr_entry.val  = sat_sum;
	assign wr_entry.mark = mark_base | ovf_now;

	`MMA_ASSERT_NXT(a_ovf_sticky, ctl_s2.issue && ovf_now, mark_q, "overflow not kept in mark")
	`MMA_ASSERT_IMP(a_beat_chain, ctl_s2.issue && !ctl_s2.first, $past(ctl_s2.issue), "gap inside a sum")
	`MMA_ASSERT_NXT(a_new_elem, wr_en, !ctl_s2.issue || ctl_s2.first, "sum continued after write")

endmodule

`default_nettype wire

// ===== sv/matrix_multiply_accumulate.sv =====
// top level of the square matrix multiply-accumulate engine
//
//  channel   signals                            direction  word
//  s_        s_tvalid s_tready s_tdata s_tuser  in         one command
//  m_        m_tvalid m_tready m_tdata m_tuser  out        one result per command
//  cfg_      cfg_valid cfg_ready cfg_data       in         active size n
//
// writes of A or B, errors and unused codes are answered from the accept cycle; a read of C passes ST_RD and ST_RESP
// multiply starts the sequencer, issues one beat per i, j, k on the one shared multiplier, then drains and answers
// clear sweeps all MAX_DIM*MAX_DIM C entries, one C entry per cycle through the write port, then answers
// after reset the same sweep runs before s_tready rises
// a waiting result does not block the next command; a second one waits in a holding register
`default_nettype none
`include "matrix_multiply_accumulate_macros.svh"

module matrix_multiply_accumulate #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [mma_pkg::IN_DATA_W-1:0]       s_tdata,  // row[3:0] col[7:4] value[39:8]
	input  wire logic [mma_pkg::ACT_W-1:0]           s_tuser,  // action[2:0]
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [mma_pkg::ACC_W-1:0]                m_tdata,  // read_value[63:0]
	output logic [mma_pkg::OUT_USER_W-1:0]           m_tuser,  // overflow[0] status[1]
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mma_pkg::SIZE_W-1:0]          cfg_data
);
	import mma_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int IW    = $clog2(DEPTH);
	localparam int DW    = $clog2(MAX_DIM);
	localparam int NW    = $clog2(MAX_DIM+1);
	localparam int CW    = (NW > RC_W) ? NW : RC_W;
	localparam int SWW   = (NW > SIZE_W) ? NW : SIZE_W;
	localparam logic [IW-1:0] CLR_LAST = IW'(DEPTH-1);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_MAC,
		ST_RESP
	} top_state_t;

	top_state_t                state_q;
	logic [IW-1:0]             clr_q;
	logic                      clr_resp_q;
	logic [SIZE_W-1:0]         size_q;
	logic [NW-1:0]             n_act;

	logic signed [VAL_W-1:0]   mem_a [DEPTH];
	logic signed [VAL_W-1:0]   mem_b [DEPTH];
	c_entry_t                  mem_c [DEPTH];
	logic signed [VAL_W-1:0]   a_rd_q, b_rd_q;
	c_entry_t                  c_rd_q;

	action_t                   act;
	logic [RC_W-1:0]           row, col;
	logic signed [VAL_W-1:0]   value;
	logic                      acc, oob, imm_item, imm_st, out_free, out_load;
	logic [IW-1:0]             widx, aidx, bidx, cidx_s0, c_radr;

	logic [DW-1:0]             idx_i, idx_j, idx_k;
	mma_ctl_t                  seq_ctl;
	logic                      seq_done;
	logic                      mac_wr_en;
	logic [IW-1:0]             mac_wr_idx;
	c_entry_t                  mac_wr_entry;

	logic signed [ACC_W-1:0]   res_val_q;
	logic                      res_ovf_q, res_st_q;
	logic                      m_tvalid_q;
	logic [ACC_W-1:0]          m_tdata_q;
	logic [OUT_USER_W-1:0]     m_tuser_q;

	// configuration register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RST;
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	// active size clamped to 1..MAX_DIM
	always_comb begin
		if (size_q == '0) begin
			n_act = NW'(1);
		end else if (SWW'(size_q) > SWW'(MAX_DIM)) begin
			n_act = NW'(MAX_DIM);
		end else begin
			n_act = NW'(size_q);
		end
	end

	// input word fields
	assign act   = action_t'(s_tuser);
	assign row   = s_tdata[3:0];
	assign col   = s_tdata[7:4];
	assign value = s_tdata[39:8];
	assign oob   = (CW'(row) >= CW'(n_act)) || (CW'(col) >= CW'(n_act));

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// store addresses
	assign widx    = IW'(row)   * IW'(MAX_DIM) + IW'(col);
	assign aidx    = IW'(idx_i) * IW'(MAX_DIM) + IW'(idx_k);
	assign bidx    = IW'(idx_k) * IW'(MAX_DIM) + IW'(idx_j);
	assign cidx_s0 = IW'(idx_i) * IW'(MAX_DIM) + IW'(idx_j);
	assign c_radr  = (state_q == ST_IDLE) ? widx : cidx_s0;

	// commands answered in the accept cycle if the output register is free
	always_comb begin
		unique case (act)
			ACT_WR_A, ACT_WR_B: begin
				imm_item = 1'b1;
				imm_st   = oob;
			end
			ACT_RD: begin
				imm_item = oob;
				imm_st   = oob;
			end
			ACT_MAC, ACT_CLR: begin
				imm_item = 1'b0;
				imm_st   = 1'b0;
			end
			default: begin
				imm_item = 1'b1;
				imm_st   = 1'b0;
			end
		endcase
	end

	assign out_load = (acc && imm_item && out_free) || ((state_q == ST_RESP) && out_free);

	// operand stores
	always_ff @(posedge clk) begin
		if (acc && (act == ACT_WR_A) && !oob) begin
			mem_a[widx] <= value;
		end
		a_rd_q <= mem_a[aidx];
	end

	always_ff @(posedge clk) begin
		if (acc && (act == ACT_WR_B) && !oob) begin
			mem_b[widx] <= value;
		end
		b_rd_q <= mem_b[bidx];
	end

	// result store: clear sweep or write back, one read port
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			mem_c[clr_q] <= '0;
		end else if (mac_wr_en) begin
			mem_c[mac_wr_idx] <= mac_wr_entry;
		end
		c_rd_q <= mem_c[c_radr];
	end

	mma_seq #(
		.MAX_DIM (MAX_DIM)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc && (act == ACT_MAC)),
		.n_act  (n_act),
		.idx_i  (idx_i),
		.idx_j  (idx_j),
		.idx_k  (idx_k),
		.ctl    (seq_ctl),
		.done   (seq_done)
	);

	mma_mac #(
		.MAX_DIM (MAX_DIM)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s0   (seq_ctl),
		.cidx_s0  (cidx_s0),
		.a_rd     (a_rd_q),
		.b_rd     (b_rd_q),
		.c_rd     (c_rd_q),
		.wr_en    (mac_wr_en),
		.wr_idx   (mac_wr_idx),
		.wr_entry (mac_wr_entry)
	);

	// command sequencer and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			clr_resp_q <= 1'b0;
			res_val_q  <= '0;
			res_ovf_q  <= 1'b0;
			res_st_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// output word
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				if (state_q == ST_RESP) begin
					m_tdata_q <= res_val_q;
					m_tuser_q <= {res_st_q, res_ovf_q};
				end else begin
					m_tdata_q <= '0;
					m_tuser_q <= {imm_st, 1'b0};
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLR: begin
					if (clr_q == CLR_LAST) begin
						clr_q      <= '0;
						clr_resp_q <= 1'b0;
						state_q    <= clr_resp_q ? ST_RESP : ST_IDLE;
					end else begin
						clr_q <= clr_q + IW'(1);
					end
				end
				ST_IDLE: begin
					if (acc) begin
						res_val_q <= '0;
						res_ovf_q <= 1'b0;
						res_st_q  <= imm_st;
						if (imm_item) begin
							if (!out_free) begin
								state_q <= ST_RESP;
							end
						end else if (act == ACT_RD) begin
							state_q <= ST_RD;
						end else if (act == ACT_MAC) begin
							state_q <= ST_MAC;
						end else begin
							clr_resp_q <= 1'b1;
							state_q    <= ST_CLR;
						end
					end
				end
				ST_RD: begin
					res_val_q <= c_rd_q.val;
					res_ovf_q <= c_rd_q.mark;
					res_st_q  <= 1'b0;
					state_q   <= ST_RESP;
				end
				ST_MAC: begin
					if (seq_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`MMA_ASSERT_IMP(a_wb_in_mac, mac_wr_en, state_q == ST_MAC, "write back outside multiply")
	`MMA_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser[1], m_tdata == '0 && !m_tuser[0], "error word not zero")
	`MMA_ASSERT_NXT(a_clr_end, state_q == ST_CLR && clr_q == CLR_LAST, state_q == ST_IDLE || state_q == ST_RESP, "clear sweep did not end")

endmodule

`default_nettype wire
